### design/dps_pkg.sv
`default_nettype none
package dps_pkg;

  localparam int NumSlotsDefault = 8;

  localparam int InDataW  = 24;
  localparam int OutDataW = 48;
  localparam int EntryW   = 25;

  localparam logic OpLoad = 1'b0;
  localparam logic OpTick = 1'b1;

  localparam logic [1:0] KindLoadOk  = 2'd0;
  localparam logic [1:0] KindLoadRej = 2'd1;
  localparam logic [1:0] KindRan     = 2'd2;
  localparam logic [1:0] KindIdle    = 2'd3;

  localparam logic signed [8:0] PrioFloor = -9'sd255;

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StLast,
    StCommit
  } state_e;

  typedef struct packed {
    logic start;
    logic scan;
    logic commit;
  } dps_cmd_t;

  typedef struct packed {
    logic in_op;
    logic scan_last;
    logic out_free;
  } dps_sts_t;

endpackage
`default_nettype wire

### design/dps_ram.sv
`default_nettype none
module dps_ram #(
  parameter int Width = 8,
  parameter int Depth = 8
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

### design/dps_ctrl.sv
`default_nettype none
module dps_ctrl import dps_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire dps_sts_t sts_i,
  output dps_cmd_t      cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = (sts_i.in_op == OpTick) ? StScan : StCommit;
        end
      end
      StScan: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_last) begin
          state_d = StLast;
        end
      end
      StLast: begin
        state_d = StCommit;
      end
      StCommit: begin
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

endmodule
`default_nettype wire

### design/dps_datapath.sv
`default_nettype none
module dps_datapath import dps_pkg::*; #(
  parameter int SLOTS = NumSlotsDefault
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic [InDataW-1:0]  in_tdata_i,
  input  wire logic                in_tuser_i,
  input  wire dps_cmd_t            cmd_i,
  output dps_sts_t                 sts_o,
  output logic                     out_tvalid_o,
  input  wire logic                out_tready_i,
  output logic [OutDataW-1:0]      out_tdata_o,
  output logic [1:0]               out_tuser_o
);

  localparam int IdxW = $clog2(SLOTS);
  localparam int CntW = $clog2(SLOTS + 1);

  logic                    op_q;
  logic [7:0]              id_q, rt_q, pi_q;
  logic [SLOTS-1:0]        valid_q, valid_d;
  logic [CntW-1:0]         scan_cnt_q;
  logic                    cmp_en_q;
  logic [IdxW-1:0]         cmp_idx_q;
  logic                    best_found_q;
  logic [IdxW-1:0]         best_idx_q;
  logic [7:0]              best_id_q, best_time_q;
  logic signed [8:0]       best_prio_q;
  logic [15:0]             turns_q, turns_d;
  logic                    out_valid_q;
  logic [OutDataW-1:0]     out_data_q, out_data_d;
  logic [1:0]              out_kind_q, out_kind_d;

  logic                    ram_we;
  logic [IdxW-1:0]         ram_waddr;
  logic [EntryW-1:0]       ram_wdata, ram_rdata;
  logic [7:0]              rd_id, rd_time;
  logic signed [8:0]       rd_prio;

  logic [IdxW-1:0]         free_idx;
  logic                    full;
  logic [7:0]              new_time;
  logic signed [8:0]       new_prio;
  logic [7:0]              res_id, res_time;
  logic signed [8:0]       res_prio;
  logic                    res_fin, res_ran;

  dps_ram #(
    .Width(EntryW),
    .Depth(SLOTS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (cmd_i.scan),
    .raddr_i(scan_cnt_q[IdxW-1:0]),
    .rdata_o(ram_rdata)
  );

  assign rd_id   = ram_rdata[7:0];
  assign rd_time = ram_rdata[15:8];
  assign rd_prio = $signed(ram_rdata[24:16]);

  always_comb begin
    free_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_idx = IdxW'(i);
      end
    end
  end

  assign full     = &valid_q;
  assign new_time = best_time_q - 8'd1;
  assign new_prio = (best_prio_q > PrioFloor) ? best_prio_q - 9'sd1 : best_prio_q;

  assign sts_o.in_op     = in_tuser_i;
  assign sts_o.scan_last = (scan_cnt_q == CntW'(SLOTS - 1));
  assign sts_o.out_free  = !out_valid_q || out_tready_i;

  always_comb begin
    valid_d    = valid_q;
    turns_d    = turns_q;
    ram_we     = 1'b0;
    ram_waddr  = best_idx_q;
    ram_wdata  = {new_prio, new_time, best_id_q};
    out_kind_d = KindIdle;
    res_id     = '0;
    res_time   = '0;
    res_prio   = '0;
    res_fin    = 1'b0;
    res_ran    = 1'b0;
    if (op_q == OpLoad) begin
      res_id = id_q;
      if (full) begin
        out_kind_d = KindLoadRej;
      end else begin
        out_kind_d = KindLoadOk;
        res_time   = rt_q;
        res_prio   = $signed({1'b0, pi_q});
        ram_we     = cmd_i.commit;
        ram_waddr  = free_idx;
        ram_wdata  = {1'b0, pi_q, rt_q, id_q};
        valid_d[free_idx] = 1'b1;
      end
    end else if (best_found_q) begin
      out_kind_d = KindRan;
      turns_d    = turns_q + 16'd1;
      res_id     = best_id_q;
      if (best_time_q == 8'd0) begin
        res_prio = best_prio_q;
        res_fin  = 1'b1;
        valid_d[best_idx_q] = 1'b0;
      end else begin
        ram_we   = cmd_i.commit;
        res_time = new_time;
        res_prio = new_prio;
        res_ran  = 1'b1;
        res_fin  = (new_time == 8'd0);
        if (new_time == 8'd0) begin
          valid_d[best_idx_q] = 1'b0;
        end
      end
    end
    out_data_d = {5'd0, turns_d, res_ran, res_fin, res_prio, res_time, res_id};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q      <= '0;
      turns_q      <= '0;
      out_valid_q  <= 1'b0;
      scan_cnt_q   <= '0;
      cmp_en_q     <= 1'b0;
      best_found_q <= 1'b0;
    end else begin
      cmp_en_q <= cmd_i.scan;
      if (cmd_i.start) begin
        scan_cnt_q   <= '0;
        best_found_q <= 1'b0;
      end else if (cmd_i.scan) begin
        scan_cnt_q <= scan_cnt_q + CntW'(1);
      end
      if (cmp_en_q && valid_q[cmp_idx_q] && (!best_found_q || rd_prio > best_prio_q)) begin
        best_found_q <= 1'b1;
      end
      if (cmd_i.commit) begin
        valid_q     <= valid_d;
        turns_q     <= turns_d;
        out_valid_q <= 1'b1;
      end else if (out_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      op_q <= in_tuser_i;
      id_q <= in_tdata_i[7:0];
      rt_q <= in_tdata_i[15:8];
      pi_q <= in_tdata_i[23:16];
    end
    cmp_idx_q <= scan_cnt_q[IdxW-1:0];
    if (cmp_en_q && valid_q[cmp_idx_q] && (!best_found_q || rd_prio > best_prio_q)) begin
      best_idx_q  <= cmp_idx_q;
      best_id_q   <= rd_id;
      best_time_q <= rd_time;
      best_prio_q <= rd_prio;
    end
    if (cmd_i.commit) begin
      out_data_q <= out_data_d;
      out_kind_q <= out_kind_d;
    end
  end

  assign out_tvalid_o = out_valid_q;
  assign out_tdata_o  = out_data_q;
  assign out_tuser_o  = out_kind_q;

endmodule
`default_nettype wire

### design/dynamic_priority_scheduler.sv
// A load word is accepted, then committed to the output register; a tick word
// is accepted, then the slot table is scanned (one table read per cycle), then
// committed. The block holds one word at a time: a new word is accepted only
// once the last one is committed. A new word is taken while a result waits;
// its commit holds until that result is taken.
// Reset clears the valid bits, the turn counter and the output valid flag.
`default_nettype none
module dynamic_priority_scheduler import dps_pkg::*; #(
  parameter int SLOTS = NumSlotsDefault
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  // proc_id[7:0], run_time[15:8], prio_in[23:16]
  input  wire logic [InDataW-1:0]  s_axis_tdata,
  // op[0]
  input  wire logic [0:0]          s_axis_tuser,
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // sel_id[7:0], time_left[15:8], prio_now[24:16], finished[25], ran[26],
  // turn_count[42:27], zero[47:43]
  output logic [OutDataW-1:0]      m_axis_tdata,
  // kind[1:0]
  output logic [1:0]               m_axis_tuser
);

  dps_cmd_t cmd;
  dps_sts_t sts;

  dps_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  dps_datapath #(
    .SLOTS(SLOTS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_tdata_i  (s_axis_tdata),
    .in_tuser_i  (s_axis_tuser[0]),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_tvalid_o(m_axis_tvalid),
    .out_tready_i(m_axis_tready),
    .out_tdata_o (m_axis_tdata),
    .out_tuser_o (m_axis_tuser)
  );

  a_scan_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.scan |-> !s_axis_tready)
    else $error("scan while accepting");

  a_commit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |-> (!m_axis_tvalid || m_axis_tready))
    else $error("commit over a pending result");

  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.start |=> !s_axis_tready)
    else $error("ready right after accept");

  a_commit_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |=> m_axis_tvalid)
    else $error("result lost after commit");

endmodule
`default_nettype wire

### tb/testbench.sv
`timescale 1ns / 100ps
module testbench;
  import dps_pkg::*;

  localparam int SLOTS = NumSlotsDefault;
  localparam int CycleLimit = 400000;
  localparam int ResultLatency = SLOTS + 3;

  typedef struct packed {
    logic       op;
    logic [7:0] id;
    logic [7:0] run_time;
    logic [7:0] prio;
  } sched_word_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [7:0]        sel_id;
    logic [7:0]        time_left;
    logic signed [8:0] prio_now;
    logic              finished;
    logic              ran;
    logic [15:0]       turn_count;
    logic [4:0]        pad;
  } sched_result_t;

  logic                clk_i;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic [0:0]          s_axis_tuser = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic [1:0]          m_axis_tuser;

  sched_word_t   pending_words[$];
  sched_result_t due_results[$];

  logic              tbl_valid [SLOTS];
  logic [7:0]        tbl_id    [SLOTS];
  logic [7:0]        tbl_time  [SLOTS];
  logic signed [8:0] tbl_prio  [SLOTS];
  logic [15:0]       turn_cnt;

  int send_gap_pct;
  int recv_stall_pct;
  int errors;
  int cycles;
  int words_in;
  int results_seen;
  int runs_seen;
  int retire_seen;
  int reject_seen;
  int idle_seen;

  dynamic_priority_scheduler #(.SLOTS(SLOTS)) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic sched_result_t schedule_word(sched_word_t w);
    sched_result_t r;
    int best;
    r = '0;
    best = -1;
    if (w.op == OpLoad) begin
      r.kind = KindLoadRej;
      r.sel_id = w.id;
      for (int i = 0; i < SLOTS; i++) begin
        if (!tbl_valid[i] && best < 0) best = i;
      end
      if (best >= 0) begin
        tbl_valid[best] = 1'b1;
        tbl_id[best] = w.id;
        tbl_time[best] = w.run_time;
        tbl_prio[best] = $signed({1'b0, w.prio});
        r.kind = KindLoadOk;
        r.time_left = w.run_time;
        r.prio_now = tbl_prio[best];
      end
    end else begin
      r.kind = KindIdle;
      for (int i = 0; i < SLOTS; i++) begin
        if (tbl_valid[i] && (best < 0 || tbl_prio[i] > tbl_prio[best])) best = i;
      end
      if (best >= 0) begin
        turn_cnt++;
        r.kind = KindRan;
        r.sel_id = tbl_id[best];
        if (tbl_time[best] == 8'd0) begin
          tbl_valid[best] = 1'b0;
          r.finished = 1'b1;
          r.prio_now = tbl_prio[best];
        end else begin
          tbl_time[best]--;
          if (tbl_prio[best] > PrioFloor) tbl_prio[best]--;
          r.ran = 1'b1;
          r.time_left = tbl_time[best];
          r.prio_now = tbl_prio[best];
          if (tbl_time[best] == 8'd0) begin
            r.finished = 1'b1;
            tbl_valid[best] = 1'b0;
          end
        end
      end
    end
    r.turn_count = turn_cnt;
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    if (errors < 50) $display("[%0t] mismatch: %s", $time, msg);
    errors++;
  endtask

  task automatic compare_field(string name, logic [15:0] got, logic [15:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("result %0d %s: got %0h, want %0h",
                                results_seen, name, got, want));
    end
  endtask

  task automatic push_word(logic op, logic [7:0] id, logic [7:0] rt, logic [7:0] pi);
    pending_words.insert(pending_words.size(), sched_word_t'({op, id, rt, pi}));
  endtask

  function automatic logic [7:0] pick_time();
    int r;
    r = $urandom_range(99);
    if (r < 70) return 8'($urandom_range(4));
    if (r < 96) return 8'($urandom_range(31, 5));
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [7:0] pick_prio();
    int r;
    r = $urandom_range(99);
    if (r < 25) return 8'($urandom_range(123, 120));
    if (r < 35) return ($urandom_range(1) != 0) ? 8'd255 : 8'd0;
    return 8'($urandom_range(255));
  endfunction

  task automatic queue_random(int n);
    int load_pct;
    int k;
    k = 0;
    while (k < n) begin
      load_pct = $urandom_range(80, 20);
      repeat ($urandom_range(20, 6)) begin
        if ($urandom_range(99) < load_pct) begin
          push_word(OpLoad, 8'($urandom_range(255)), pick_time(), pick_prio());
        end else begin
          push_word(OpTick, 8'($urandom_range(255)), 8'($urandom_range(255)),
                    8'($urandom_range(255)));
        end
        k++;
      end
    end
  endtask

  task automatic wait_idle();
    while (pending_words.size() != 0 || s_axis_tvalid || due_results.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : drive
    sched_word_t w;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        due_results.insert(due_results.size(),
                           schedule_word({s_axis_tuser[0], s_axis_tdata[7:0],
                                          s_axis_tdata[15:8], s_axis_tdata[23:16]}));
        words_in++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_words.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          w = pending_words[0];
          pending_words.delete(0);
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= {w.prio, w.run_time, w.id};
          s_axis_tuser <= w.op;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin : watch
    sched_result_t got;
    sched_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[15:8], m_axis_tdata[24:16],
             m_axis_tdata[25], m_axis_tdata[26], m_axis_tdata[42:27], m_axis_tdata[47:43]};
      if (due_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result, kind %0d id %0h",
                                  got.kind, got.sel_id));
      end else begin
        want = due_results[0];
        due_results.delete(0);
        compare_field("kind", 16'(got.kind), 16'(want.kind));
        compare_field("sel_id", 16'(got.sel_id), 16'(want.sel_id));
        compare_field("time_left", 16'(got.time_left), 16'(want.time_left));
        compare_field("prio_now", 16'(unsigned'(got.prio_now)),
                      16'(unsigned'(want.prio_now)));
        compare_field("finished", 16'(got.finished), 16'(want.finished));
        compare_field("ran", 16'(got.ran), 16'(want.ran));
        compare_field("turn_count", got.turn_count, want.turn_count);
        compare_field("pad", 16'(got.pad), 16'(want.pad));
        if (want.kind == KindRan) runs_seen++;
        if (want.finished) retire_seen++;
        if (want.kind == KindLoadRej) reject_seen++;
        if (want.kind == KindIdle) idle_seen++;
      end
      results_seen++;
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    int drain;
    foreach (tbl_valid[i]) tbl_valid[i] = 1'b0;
    turn_cnt = '0;
    send_gap_pct = 0;
    recv_stall_pct = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    push_word(OpTick, 8'hFF, 8'hFF, 8'hFF);
    push_word(OpLoad, 8'h00, 8'd0, 8'd255);
    push_word(OpLoad, 8'hFF, 8'd255, 8'd0);
    push_word(OpLoad, 8'hA5, 8'd1, 8'd255);
    push_word(OpLoad, 8'h5A, 8'd2, 8'd128);
    push_word(OpLoad, 8'h01, 8'd3, 8'd127);
    push_word(OpLoad, 8'h02, 8'd1, 8'd0);
    push_word(OpLoad, 8'h03, 8'd254, 8'd1);
    push_word(OpLoad, 8'h04, 8'd1, 8'd255);
    push_word(OpLoad, 8'h63, 8'd9, 8'd200);
    repeat (6) push_word(OpTick, 8'h00, 8'h00, 8'h00);
    push_word(OpLoad, 8'h80, 8'd0, 8'd0);
    push_word(OpLoad, 8'h7F, 8'd128, 8'd254);
    repeat (4) push_word(OpTick, 8'h55, 8'hAA, 8'h55);
    wait_idle();

    // empty the table, then push one process down to the priority floor
    drain = 0;
    foreach (tbl_valid[i]) begin
      if (tbl_valid[i]) drain += (tbl_time[i] == 8'd0) ? 1 : int'(tbl_time[i]);
    end
    repeat (drain) push_word(OpTick, 8'h00, 8'h00, 8'h00);
    push_word(OpLoad, 8'h7E, 8'd255, 8'd0);
    repeat (256) push_word(OpTick, 8'($urandom_range(255)), 8'h00, 8'h00);
    queue_random(125);
    wait_idle();

    send_gap_pct = 52;
    queue_random(125);
    wait_idle();

    send_gap_pct = 0;
    recv_stall_pct = 52;
    queue_random(125);
    wait_idle();

    send_gap_pct = 30;
    recv_stall_pct = 30;
    queue_random(125);
    wait_idle();

    repeat (2 * ResultLatency) @(posedge clk_i);
    $display("Sent %0d words under four pacing mixes, checked %0d results.",
             words_in, results_seen);
    $display("Seen: %0d turns run, %0d retirements, %0d full-table rejects, %0d idle ticks.",
             runs_seen, retire_seen, reject_seen, idle_seen);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
